// File: hdl/hmsf_pkg.sv
// ----------------------------------------------------------------------------
// Histogram mode finder package
// Shared state encoding, command codes and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hmsf_pkg;

  // Input item kinds carried on the slave tuser bit.
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Fixed field widths of the stream payloads.
  localparam int unsigned VALUE_W      = 7;
  localparam int unsigned MODE_COUNT_W = 16;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_MAX,
    ST_MAX_TAIL,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_en;       // read the bin at the address port
    logic wr_en;       // write back the incremented bin at the last read address
    logic clr;         // zero all bins and the top count
    logic max_upd;     // fold the read bin into the top count
    logic emit_chk;    // check the read bin against the top count
    logic emit_flush;  // send the pending mode value as the final beat
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // read bin equals the top count
    logic pend_vld;    // a mode value waits to be sent
    logic out_free;    // the output register can take a beat this cycle
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/hmsf_ctrl.sv
// ----------------------------------------------------------------------------
// Histogram mode finder controller
// Sequences record, clear, the top count pass and the emit pass over the bins.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsf_ctrl #(
  parameter int unsigned BINS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic                  s_cmd_i,
  input  wire logic [6:0]            s_value_i,
  input  wire logic                  s_last_i,
  input  wire hmsf_pkg::dp_sts_t     sts_i,
  output hmsf_pkg::dp_cmd_t          cmd_o,
  output logic [$clog2(BINS)-1:0]    addr_o
);

  import hmsf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BINS);
  localparam int unsigned IDX_W  = $clog2(BINS + 1);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic               last_q, last_d;
  logic               in_range;
  logic               stall;
  logic [ADDR_W-1:0]  value_addr;

  // Decode of the incoming value into a bin address.
  assign in_range   = (s_value_i != 7'd0) && (s_value_i <= 7'(BINS));
  assign value_addr = ADDR_W'(s_value_i - 7'd1);

  // The emit pass waits when a second mode value shows up while a beat is stuck.
  assign stall = rd_vld_q && sts_i.hit && sts_i.pend_vld && !sts_i.out_free;

  // State and sequencing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      last_q   <= last_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rd_vld_d  = rd_vld_q;
    last_d    = last_q;
    cmd_o     = '0;
    addr_o    = idx_q[ADDR_W-1:0];
    s_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          last_d = s_last_i;
          if (s_cmd_i == CMD_CLEAR) begin
            cmd_o.clr = 1'b1;
          end else if (in_range) begin
            cmd_o.rd_en = 1'b1;
            addr_o      = value_addr;
            state_d     = ST_REC;
          end else if (s_last_i) begin
            idx_d    = '0;
            rd_vld_d = 1'b0;
            state_d  = ST_MAX;
          end
        end
      end

      ST_REC: begin
        cmd_o.wr_en = 1'b1;
        if (last_q) begin
          idx_d    = '0;
          rd_vld_d = 1'b0;
          state_d  = ST_MAX;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Reads one bin per cycle and folds the previous one into the top count.
      ST_MAX: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.max_upd = rd_vld_q;
        rd_vld_d      = 1'b1;
        if (idx_q == IDX_W'(BINS - 1)) begin
          state_d = ST_MAX_TAIL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_MAX_TAIL: begin
        cmd_o.max_upd = rd_vld_q;
        rd_vld_d      = 1'b0;
        idx_d         = '0;
        state_d       = ST_EMIT;
      end

      // Reads one bin per cycle unless stalled on the output, and compares the previous one with the top count.
      ST_EMIT: begin
        if (!stall) begin
          cmd_o.emit_chk = rd_vld_q;
          if (idx_q < IDX_W'(BINS)) begin
            cmd_o.rd_en = 1'b1;
            idx_d       = idx_q + 1'b1;
            rd_vld_d    = 1'b1;
          end else begin
            rd_vld_d = 1'b0;
            if (!rd_vld_q) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/hmsf_dpath.sv
// ----------------------------------------------------------------------------
// Histogram mode finder datapath
// Bin memory with per-bin valid bits, top count, pending mode value and the
// output register of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsf_dpath #(
  parameter int unsigned BINS        = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hmsf_pkg::dp_cmd_t     cmd_i,
  input  wire logic [$clog2(BINS)-1:0] addr_i,
  output hmsf_pkg::dp_sts_t          sts_o,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output logic [6:0]                 mode_value_o,
  output logic [15:0]                mode_count_o,
  output logic                       final_mode_o
);

  import hmsf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BINS);

  logic [COUNT_WIDTH-1:0] mem_q [BINS];
  logic [BINS-1:0]        bin_vld_q;
  logic [COUNT_WIDTH-1:0] rd_raw_q;
  logic                   rd_ok_q;
  logic [ADDR_W-1:0]      rd_addr_q;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] inc_data;
  logic [COUNT_WIDTH-1:0] top_q;
  logic                   pend_vld_q;
  logic [VALUE_W-1:0]     pend_val_q;
  logic [VALUE_W-1:0]     bin_value;
  logic                   out_vld_q;
  logic [VALUE_W-1:0]     out_val_q;
  logic [MODE_COUNT_W-1:0] out_cnt_q;
  logic                   out_last_q;
  logic                   hit;
  logic                   out_free;
  logic                   push_mid;
  logic                   push_fin;

  // A bin never written since the last clear reads as zero.
  assign rd_data   = rd_ok_q ? rd_raw_q : '0;
  assign inc_data  = (&rd_data) ? rd_data : rd_data + 1'b1;
  assign bin_value = VALUE_W'({1'b0, rd_addr_q} + 1'b1);

  assign hit      = (rd_data == top_q);
  assign out_free = !out_vld_q || m_ready_i;
  assign push_mid = cmd_i.emit_chk && hit && pend_vld_q;
  assign push_fin = cmd_i.emit_flush;

  assign sts_o.hit      = hit;
  assign sts_o.pend_vld = pend_vld_q;
  assign sts_o.out_free = out_free;

  // Bin memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[rd_addr_q] <= inc_data;
    end
    if (cmd_i.rd_en) begin
      rd_raw_q  <= mem_q[addr_i];
      rd_addr_q <= addr_i;
    end
  end

  // Valid bits, read qualifier and top count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      rd_ok_q   <= 1'b0;
      top_q     <= '0;
    end else begin
      if (cmd_i.clr) begin
        bin_vld_q <= '0;
        top_q     <= '0;
      end else begin
        if (cmd_i.wr_en) begin
          bin_vld_q[rd_addr_q] <= 1'b1;
        end
        if (cmd_i.max_upd && (rd_data > top_q)) begin
          top_q <= rd_data;
        end
      end
      if (cmd_i.rd_en) begin
        rd_ok_q <= bin_vld_q[addr_i];
      end
    end
  end

  // Pending mode value and output beat control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.emit_chk && hit) begin
        pend_vld_q <= 1'b1;
      end else if (push_fin) begin
        pend_vld_q <= 1'b0;
      end
      if (push_mid || push_fin) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_chk && hit) begin
      pend_val_q <= bin_value;
    end
    if (push_mid || push_fin) begin
      out_val_q  <= pend_val_q;
      out_cnt_q  <= MODE_COUNT_W'(top_q);
      out_last_q <= push_fin;
    end
  end

  assign m_valid_o    = out_vld_q;
  assign mode_value_o = out_val_q;
  assign mode_count_o = out_cnt_q;
  assign final_mode_o = out_last_q;

  // The final beat always has a mode value behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_flush |-> pend_vld_q)
    else $error("flush without a pending mode value");

  // A beat is never pushed over one that still waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_mid || push_fin) |-> out_free)
    else $error("output beat overwritten");

  // A clear leaves every bin and the top count at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |=> ((bin_vld_q == '0) && (top_q == '0)))
    else $error("clear did not empty the histogram");

endmodule

`default_nettype wire

// File: hdl/histogram_mode_set_finder_core.sv
// A record beat reads its bin and then writes back the incremented count; a clear beat and an
// ignored value need only the accepting step. A batch-ending beat adds a top count pass and
// an emit pass over the bins, and the emit pass waits while a mode value waits on a stalled output.
// The core takes one beat at a time and no new beat during a batch end, since the single read
// port of the bin memory is walked twice.
// Reset: all bins and the top count read as zero at once through per-bin valid bits.
// ----------------------------------------------------------------------------
// Histogram mode set finder core
// Counts values 1..BINS in saturating bins and, at the end of a batch, streams
// every value whose count equals the top count in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_mode_set_finder_core #(
  parameter int unsigned BINS        = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [6:0] value, [7] zero fill
  input  wire logic        s_axis_tuser_i,   // [0] cmd
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [6:0] mode_value, [22:7] mode_count, [23] zero
  output logic             m_axis_tlast_o
);

  import hmsf_pkg::*;

  dp_cmd_t                 dp_cmd;
  dp_sts_t                 dp_sts;
  logic [$clog2(BINS)-1:0] dp_addr;
  logic [6:0]              mode_value;
  logic [15:0]             mode_count;

  // Sequencer for record, clear and the two bin passes.
  hmsf_ctrl #(
    .BINS (BINS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_cmd_i   (s_axis_tuser_i),
    .s_value_i (s_axis_tdata_i[6:0]),
    .s_last_i  (s_axis_tlast_i),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd),
    .addr_o    (dp_addr)
  );

  // Bin storage, top count and result stream.
  hmsf_dpath #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .addr_i       (dp_addr),
    .sts_o        (dp_sts),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .mode_value_o (mode_value),
    .mode_count_o (mode_count),
    .final_mode_o (m_axis_tlast_o)
  );

  // Result beat packing.
  assign m_axis_tdata_o = {1'b0, mode_count, mode_value};

endmodule

`default_nettype wire

// File: tb/histogram_mode_set_finder_core_tb.sv
// ----------------------------------------------------------------------------
// Histogram mode set finder core testbench
// Drives record and clear beats into the core and checks every mode beat it
// streams out against a histogram kept alongside or a row of a short table. The table covers the
// edges: the empty histogram, values outside 1..BINS, clears and a single
// leading bin. Random batches follow. The input side sends in bursts with
// gaps, and the output side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_mode_set_finder_core_tb;

  import hmsf_pkg::*;

  localparam int unsigned BINS         = 64;
  localparam int unsigned COUNT_WIDTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 75;
  localparam int unsigned DRAIN_CYCLES = 2 * BINS + 16;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // How the expectation of a table row is formed.
  typedef enum logic [1:0] {
    EXP_MODEL,  // taken from the histogram kept here
    EXP_NONE,   // the beat causes no mode beat
    EXP_ALL,    // every value 1..BINS with the given count
    EXP_ONE     // one single mode value with the given count
  } exp_kind_e;

  typedef struct packed {
    logic [VALUE_W-1:0]      value;
    logic [MODE_COUNT_W-1:0] count;
    logic                    is_final;
  } mode_beat_t;

  typedef struct {
    logic                    cmd;
    logic [VALUE_W-1:0]      value;
    logic                    last;
    int unsigned             reps;
    exp_kind_e               kind;
    logic [VALUE_W-1:0]      exp_value;
    logic [MODE_COUNT_W-1:0] exp_count;
  } stim_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [6:0] value, [7] zero fill
  logic        s_axis_tuser_i  = 1'b0; // [0] cmd
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;         // [6:0] mode_value, [22:7] mode_count, [23] zero
  logic        m_axis_tlast_o;

  // Histogram kept by the testbench and the mode beats still to come.
  logic [COUNT_WIDTH-1:0] bin_q [BINS];
  logic [COUNT_WIDTH-1:0] top_q;
  mode_beat_t             mode_q [$];
  stim_row_t              stim_rows [$];

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;

  histogram_mode_set_finder_core #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  // Update the histogram with one accepted beat. On a batch end the top count
  // is raised and, when want_modes is set, every value at the top count is
  // queued in ascending order with the last one flagged.
  task automatic tally(input logic cmd, input logic [VALUE_W-1:0] value, input logic last,
                       input bit want_modes);
    int last_hit;
    mode_beat_t beat;
    begin
      if (cmd == CMD_CLEAR) begin
        foreach (bin_q[i]) bin_q[i] = '0;
        top_q = '0;
      end else begin
        if (value >= 1 && value <= BINS) begin
          if (bin_q[value-1] != COUNT_MAX) bin_q[value-1] = bin_q[value-1] + 1'b1;
        end
        if (last) begin
          last_hit = -1;
          foreach (bin_q[i]) if (bin_q[i] > top_q) top_q = bin_q[i];
          foreach (bin_q[i]) if (bin_q[i] == top_q) last_hit = i;
          if (want_modes) begin
            foreach (bin_q[i]) begin
              if (bin_q[i] == top_q) begin
                beat.value    = VALUE_W'(i + 1);
                beat.count    = MODE_COUNT_W'(top_q);
                beat.is_final = (i == last_hit);
                mode_q.push_back(beat);
              end
            end
          end
        end
      end
    end
  endtask

  // Send one beat. Entered and left just after a falling edge. Unless steady
  // is set, a finished burst is followed by a random gap before this beat.
  task automatic send_beat(input logic cmd, input logic [VALUE_W-1:0] value, input logic last,
                           input bit steady, input bit want_modes);
    begin
      if (!steady && burst_left == 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      end
      if (burst_left != 0) burst_left--;
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= {1'b0, value};
      s_axis_tuser_i  <= cmd;
      s_axis_tlast_i  <= last;
      do @(posedge clk_i); while (!s_axis_tready_o);
      tally(cmd, value, last, want_modes);
      @(negedge clk_i);
    end
  endtask

  task automatic add_row(input logic cmd, input logic [VALUE_W-1:0] value, input logic last,
                         input int unsigned reps, input exp_kind_e kind,
                         input logic [VALUE_W-1:0] exp_value,
                         input logic [MODE_COUNT_W-1:0] exp_count);
    stim_row_t row;
    begin
      row.cmd       = cmd;
      row.value     = value;
      row.last      = last;
      row.reps      = reps;
      row.kind      = kind;
      row.exp_value = exp_value;
      row.exp_count = exp_count;
      stim_rows.push_back(row);
    end
  endtask

  // Output side: ready and stall stretches of random length, with an
  // occasional long stretch of no stalls at all.
  always @(negedge clk_i) begin : rx_pattern
    int unsigned hold_left;
    if (hold_left != 0) begin
      hold_left--;
    end else if (m_axis_tready_i) begin
      m_axis_tready_i <= 1'b0;
      hold_left = $urandom_range(0, 5);
    end else begin
      m_axis_tready_i <= 1'b1;
      hold_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 6);
    end
  end

  // Compare each mode beat with the oldest one still expected.
  always @(posedge clk_i) begin : mode_check
    mode_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (mode_q.size() == 0) begin
        $error("unexpected mode beat: mode_value %0d mode_count %0d final_mode %0b",
               m_axis_tdata_o[6:0], m_axis_tdata_o[22:7], m_axis_tlast_o);
        err_cnt++;
      end else begin
        want = mode_q.pop_front();
        if (m_axis_tdata_o[6:0] !== want.value) begin
          $error("mode_value: expected %0d, actual %0d", want.value, m_axis_tdata_o[6:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[22:7] !== want.count) begin
          $error("mode_count: expected %0d, actual %0d", want.count, m_axis_tdata_o[22:7]);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want.is_final) begin
          $error("final_mode: expected %0b, actual %0b", want.is_final, m_axis_tlast_o);
          err_cnt++;
        end
        if (m_axis_tdata_o[23] !== 1'b0) begin
          $error("zero fill: expected 0, actual %0b", m_axis_tdata_o[23]);
          err_cnt++;
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    mode_beat_t     beat;
    stim_row_t      row;
    int unsigned    rand_items;
    int unsigned    batch_len;
    int unsigned    base;
    int unsigned    span;
    logic [VALUE_W-1:0] value;
    logic           last;
    logic           cmd;
    int unsigned    pick;

    foreach (bin_q[i]) bin_q[i] = '0;
    top_q = '0;

    //       cmd         value last reps   kind       value count
    // Empty histogram after reset; value 0 is not counted but still scans.
    add_row(CMD_RECORD,   0,  1,     1, EXP_ALL,   0,     0);
    add_row(CMD_RECORD, 127,  0,     1, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,  64,  0,     1, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,  64,  1,     1, EXP_ONE,  64,     2);
    add_row(CMD_RECORD,   1,  1,     1, EXP_MODEL, 0,     0);
    // Values just above BINS and at the field maximum change no bin.
    add_row(CMD_RECORD,  65,  1,     1, EXP_MODEL, 0,     0);
    add_row(CMD_RECORD, 127,  1,     1, EXP_MODEL, 0,     0);
    add_row(CMD_RECORD,   1,  1,     1, EXP_MODEL, 0,     0);
    // A clear ignores its value and its batch end.
    add_row(CMD_CLEAR,  127,  1,     1, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,   1,  1,     1, EXP_ONE,   1,     1);
    add_row(CMD_RECORD,  64,  1,     1, EXP_MODEL, 0,     0);
    add_row(CMD_RECORD,  32,  0,     1, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,  33,  0,     1, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,  32,  1,     1, EXP_MODEL, 0,     0);
    add_row(CMD_CLEAR,    0,  0,     1, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,   0,  1,     1, EXP_ALL,   0,     0);
    // One bin pulled ahead of all others is the single mode.
    add_row(CMD_RECORD,   7,  0,     2, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,   7,  1,     1, EXP_ONE,   7,     3);
    add_row(CMD_RECORD,   8,  1,     1, EXP_MODEL, 0,     0);
    add_row(CMD_CLEAR,    0,  0,     1, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,  42,  0,     3, EXP_NONE,  0,     0);
    add_row(CMD_RECORD,  42,  1,     1, EXP_ONE,  42,     4);

    // Reset once, then start on a falling edge.
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (stim_rows[r]) begin
      row = stim_rows[r];
      for (int unsigned k = 0; k < row.reps; k++) begin
        send_beat(row.cmd, row.value, row.last, k != 0, row.kind == EXP_MODEL);
      end
      if (row.kind == EXP_ALL) begin
        for (int v = 1; v <= BINS; v++) begin
          beat.value    = VALUE_W'(v);
          beat.count    = row.exp_count;
          beat.is_final = (v == BINS);
          mode_q.push_back(beat);
        end
      end else if (row.kind == EXP_ONE) begin
        beat.value    = row.exp_value;
        beat.count    = row.exp_count;
        beat.is_final = 1'b1;
        mode_q.push_back(beat);
      end
    end

    // Random part: mostly well-formed batches, some clears and some noise.
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // A batch of values from a narrow window gives ties; a wide one spreads.
        batch_len = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 0) begin
          span = $urandom_range(1, 4);
          base = $urandom_range(1, BINS - span + 1);
        end else begin
          span = BINS;
          base = 1;
        end
        for (int unsigned k = 0; k < batch_len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            value = ($urandom_range(0, 1) == 0) ? 7'd0 : VALUE_W'($urandom_range(BINS + 1, 127));
          end else begin
            value = VALUE_W'(base + $urandom_range(0, span - 1));
          end
          last = (k == batch_len - 1);
          send_beat(CMD_RECORD, value, last, 1'b0, 1'b1);
          if (last || (value >= 1 && value <= BINS)) rand_items++;
        end
      end else begin
        cmd   = (pick < 88) ? CMD_CLEAR : CMD_RECORD;
        value = VALUE_W'($urandom_range(0, 127));
        last  = 1'($urandom_range(0, 1));
        send_beat(cmd, value, last, 1'b0, 1'b1);
        if (cmd == CMD_CLEAR || last || (value >= 1 && value <= BINS)) rand_items++;
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain, then watch a while longer for stray beats.
    while (mode_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
